@@ rtl/core/assert_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held low.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/mexp_pkg.sv @@
`default_nettype none

package mexp_pkg;

    localparam int WIDTH_DEF = 32;
    localparam int FIELD_W   = 32;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_PREP   = 6'b000010,
        ST_DIV    = 6'b000100,
        ST_MUL    = 6'b001000,
        ST_COMMIT = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic last;
        logic mul_step;
        logic commit;
        logic finish;
    } mexp_cmd_t;

    typedef struct packed {
        logic e_zero;
        logic e_last;
        logic m_zero;
    } mexp_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/mexp_ctrl.sv @@
`default_nettype none

module mexp_ctrl import mexp_pkg::*; #(
    parameter int WIDTH = WIDTH_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    input  wire mexp_sts_t sts,
    output mexp_cmd_t      cmd
);

    localparam int CNT_W = $clog2(WIDTH);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               m_valid_reg, m_valid_next;
    logic               cnt_last;

    assign cnt_last = (cnt_reg == CNT_W'(WIDTH - 1));

    always_comb begin
        state_next = state_reg;
        cnt_next   = '0;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                // zero exponent or zero modulus: result already set at load
                if (sts.e_zero || sts.m_zero) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cmd.last     = cnt_last;
                cnt_next     = cnt_last ? '0 : CNT_W'(cnt_reg + 1'b1);
                if (cnt_last) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_last ? '0 : CNT_W'(cnt_reg + 1'b1);
                if (cnt_last) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                if (sts.e_last) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid_next = (m_valid_reg && !m_ready) || cmd.finish;
    assign m_valid      = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/mexp_dp.sv @@
`default_nettype none

module mexp_dp import mexp_pkg::*; #(
    parameter int WIDTH = WIDTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [FIELD_W-1:0] cfg_wr_data,
    input  wire logic [FIELD_W-1:0] s_base_value,
    input  wire logic [FIELD_W-1:0] s_exponent_value,
    input  wire mexp_cmd_t          cmd,
    output mexp_sts_t               sts,
    output logic [FIELD_W-1:0]      m_power_result
);

    localparam int EXT_W = (WIDTH > FIELD_W) ? WIDTH : FIELD_W;

    // field to operand: low WIDTH bits, zero extended when the field is narrower
    function automatic logic [WIDTH-1:0] to_op(input logic [FIELD_W-1:0] v);
        logic [EXT_W-1:0] t;
        t = EXT_W'(v);
        return t[WIDTH-1:0];
    endfunction

    // one conditional subtract, valid for x < 2m
    function automatic logic [WIDTH-1:0] red(input logic [WIDTH:0] x,
                                             input logic [WIDTH-1:0] m);
        logic [WIDTH:0] d;
        d = x - {1'b0, m};
        if (x >= {1'b0, m}) begin
            return d[WIDTH-1:0];
        end
        return x[WIDTH-1:0];
    endfunction

    logic [WIDTH-1:0]   mod_reg;
    logic [WIDTH-1:0]   e_reg, acc_reg, b_reg, a1_reg, a2_reg, p1_reg, p2_reg;
    logic [FIELD_W-1:0] res_reg;
    logic [WIDTH-1:0]   e_in, rem_new, new_acc, p1_add, p2_add, a1_dbl, a2_dbl;
    logic [EXT_W-1:0]   acc_ext;

    assign e_in    = to_op(s_exponent_value);
    assign rem_new = red({p2_reg, b_reg[WIDTH-1]}, mod_reg);
    assign new_acc = e_reg[0] ? p1_reg : acc_reg;
    assign p1_add  = red({1'b0, p1_reg} + {1'b0, a1_reg}, mod_reg);
    assign p2_add  = red({1'b0, p2_reg} + {1'b0, a2_reg}, mod_reg);
    assign a1_dbl  = red({a1_reg, 1'b0}, mod_reg);
    assign a2_dbl  = red({a2_reg, 1'b0}, mod_reg);
    assign acc_ext = EXT_W'(acc_reg);

    assign sts.e_zero = (e_reg == '0);
    assign sts.e_last = ((e_reg >> 1) == '0);
    assign sts.m_zero = (mod_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_reg <= WIDTH'(1);
        end else if (cfg_wr_en) begin
            mod_reg <= to_op(cfg_wr_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            b_reg  <= to_op(s_base_value);
            e_reg  <= e_in;
            p2_reg <= '0;
            // 1 unreduced for a zero exponent; a modulus of 0 or 1 gives 0
            if (e_in != '0 && mod_reg[WIDTH-1:1] == '0) begin
                acc_reg <= '0;
            end else begin
                acc_reg <= WIDTH'(1);
            end
        end
        if (cmd.div_step) begin
            if (cmd.last) begin
                // base mod m is ready: set up the first square and multiply
                b_reg  <= rem_new;
                a1_reg <= acc_reg;
                a2_reg <= rem_new;
                p1_reg <= '0;
                p2_reg <= '0;
            end else begin
                b_reg  <= b_reg << 1;
                p2_reg <= rem_new;
            end
        end
        if (cmd.mul_step) begin
            if (b_reg[0]) begin
                p1_reg <= p1_add;
                p2_reg <= p2_add;
            end
            a1_reg <= a1_dbl;
            a2_reg <= a2_dbl;
            b_reg  <= b_reg >> 1;
        end
        if (cmd.commit) begin
            acc_reg <= new_acc;
            e_reg   <= e_reg >> 1;
            b_reg   <= p2_reg;
            a1_reg  <= new_acc;
            a2_reg  <= p2_reg;
            p1_reg  <= '0;
            p2_reg  <= '0;
        end
        if (cmd.finish) begin
            res_reg <= acc_ext[FIELD_W-1:0];
        end
    end

    assign m_power_result = res_reg;

endmodule

`default_nettype wire

@@ rtl/core/modular_exponentiation_top.sv @@
// channel  direction  handshake          payload
// cfg      in         cfg_wr_en          cfg_wr_data (modulus)
// s        in         s_valid/s_ready    s_base_value, s_exponent_value
// m        out        m_valid/m_ready    m_power_result
//
// One item at a time. After acceptance: a check state, the base reduction
// (DIV), then for each exponent bit up to its highest set bit a shift-add pass
// (square and multiply side by side, MUL) and a commit, then the finish state
// loads the output register.
// A zero exponent or zero modulus goes from the check state straight to finish.
// Synchronous active-low reset; the modulus resets to 1. A stalled result
// holds the next one in its finish state.
`default_nettype none

module modular_exponentiation_top import mexp_pkg::*; #(
    parameter int WIDTH = WIDTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [FIELD_W-1:0] cfg_wr_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [FIELD_W-1:0] s_base_value,
    input  wire logic [FIELD_W-1:0] s_exponent_value,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [FIELD_W-1:0]      m_power_result
);

    mexp_cmd_t cmd;
    mexp_sts_t sts;

    mexp_ctrl #(.WIDTH(WIDTH)) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mexp_dp #(.WIDTH(WIDTH)) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_base_value     (s_base_value),
        .s_exponent_value (s_exponent_value),
        .cmd              (cmd),
        .sts              (sts),
        .m_power_result   (m_power_result)
    );

endmodule

`default_nettype wire

@@ rtl/core/mexp_checker.sv @@
`default_nettype none

`include "assert_macros.svh"

module mexp_checker import mexp_pkg::*; (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [FIELD_W-1:0] m_power_result
);

    `ASSERT_CLK(a_rst_no_result, aclk,
        !aresetn |=> !m_valid,
        "result valid after reset")

    `ASSERT_CLK_RST(a_busy_after_accept, aclk, aresetn,
        s_valid && s_ready |=> !s_ready,
        "second item taken while busy")

    `ASSERT_CLK_RST(a_no_instant_result, aclk, aresetn,
        s_valid && s_ready && !m_valid |=> !m_valid,
        "result one cycle after accept")

    `ASSERT_CLK_RST(a_result_holds, aclk, aresetn,
        m_valid && !m_ready |=> m_valid && $stable(m_power_result),
        "stalled result changed")

endmodule

bind modular_exponentiation_top mexp_checker u_mexp_checker (.*);

`default_nettype wire

@@ tb/modular_exponentiation_top_tb.sv @@
`default_nettype none

module modular_exponentiation_top_tb import mexp_pkg::*;;

    typedef struct {
        logic [FIELD_W-1:0] base;
        logic [FIELD_W-1:0] exponent;
        logic [FIELD_W-1:0] modulus;
        logic [FIELD_W-1:0] power;
    } power_case_t;

    logic               aclk;
    logic               aresetn          = 1'b0;
    logic               cfg_wr_en        = 1'b0;
    logic [FIELD_W-1:0] cfg_wr_data      = '0;
    logic               s_valid          = 1'b0;
    logic               s_ready;
    logic [FIELD_W-1:0] s_base_value     = '0;
    logic [FIELD_W-1:0] s_exponent_value = '0;
    logic               m_valid;
    logic               m_ready          = 1'b0;
    logic [FIELD_W-1:0] m_power_result;

    power_case_t        power_expected[$];
    logic [FIELD_W-1:0] modulus_shadow   = 32'd1;
    logic               calm_stretch     = 1'b0;
    int                 failures         = 0;
    int                 items_sent       = 0;
    int                 results_checked  = 0;
    int                 modulus_writes   = 0;

    modular_exponentiation_top i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_base_value     (s_base_value),
        .s_exponent_value (s_exponent_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_power_result   (m_power_result)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #8000000;
        $display("*** FAILED ***");
        $finish;
    end

    // base ** exponent mod modulus, right-to-left; products of two reduced
    // 32-bit values fit in 64 bits, so a plain remainder does the reduction
    function automatic logic [FIELD_W-1:0] predict_power(input logic [FIELD_W-1:0] base_in,
                                                          input logic [FIELD_W-1:0] exp_in);
        logic [63:0]        m;
        logic [63:0]        running;
        logic [63:0]        square;
        logic [FIELD_W-1:0] e;
        m = {32'd0, modulus_shadow};
        e = exp_in;
        running = 64'd1;
        if (e == '0) return 1;      // unreduced, even for modulus 0 or 1
        if (m == 64'd0) return 0;
        square = {32'd0, base_in} % m;
        while (e != '0) begin
            if (e[0]) running = (running * square) % m;
            square = (square * square) % m;
            e = e >> 1;
        end
        return running[FIELD_W-1:0];
    endfunction

    task automatic note_failure(input string what);
        failures++;
        if (failures <= 10) $display("%0t: %s", $realtime, what);
    endtask

    task automatic send_operands(input logic [FIELD_W-1:0] b, input logic [FIELD_W-1:0] e);
        power_case_t pc;
        while (!calm_stretch && $urandom_range(99) < 14) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_base_value     <= b;
        s_exponent_value <= e;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pc.base     = b;
        pc.exponent = e;
        pc.modulus  = modulus_shadow;
        pc.power    = predict_power(b, e);
        power_expected.push_back(pc);
        items_sent++;
    endtask

    // valid stays high between back-to-back items but for random gaps in send_operands; lowered here to drain
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (power_expected.size() != 0) @(posedge aclk);
    endtask

    task automatic set_modulus(input logic [FIELD_W-1:0] value);
        drain_results();
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en      <= 1'b0;
        modulus_shadow  = value;
        modulus_writes++;
    endtask

    // results and receiver stalls
    always @(posedge aclk) begin : result_check
        power_case_t pc;
        if (aresetn && m_valid && m_ready) begin
            if (power_expected.size() == 0) begin
                note_failure($sformatf("unexpected result %h", m_power_result));
            end else begin
                pc = power_expected.pop_front();
                results_checked++;
                if (m_power_result !== pc.power)
                    note_failure($sformatf(
                        "power_result: base %h exp %h mod %h expected %h got %h",
                        pc.base, pc.exponent, pc.modulus, pc.power, m_power_result));
            end
        end
        m_ready <= calm_stretch || ($urandom_range(99) >= 14);
    end

    task automatic test_reset_modulus();
        send_operands(32'd5, 32'd0);
        send_operands(32'd5, 32'd3);
        send_operands(32'd0, 32'd0);
    endtask

    task automatic test_zero_modulus();
        set_modulus(32'd0);
        send_operands(32'd7, 32'd0);
        send_operands(32'd7, 32'd5);
        send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_wide_moduli();
        set_modulus(32'hFFFF_FFFF);
        send_operands(32'hFFFF_FFFF, 32'd1);    // base reduces to zero
        send_operands(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_operands(32'd2, 32'd31);
        send_operands(32'd2, 32'd32);
        send_operands(32'd0, 32'd1);
        send_operands(32'd1, 32'hFFFF_FFFF);
        send_operands(32'hFFFF_FFFF, 32'd0);
        set_modulus(32'hFFFF_FFFB);             // prime: Fermat gives 1
        send_operands(32'd3, 32'hFFFF_FFFA);
        send_operands(32'd12345, 32'h8000_0000);
    endtask

    task automatic test_modulus_two();
        set_modulus(32'd2);
        send_operands(32'd3, 32'd7);
        send_operands(32'd4, 32'd1);
        send_operands(32'hAAAA_5555, 32'h5555_AAAA);
    endtask

    // most exponents short to keep the run brief, some full width
    task automatic test_random_powers(input logic [FIELD_W-1:0] modulus, input int count,
                                      input logic calm);
        logic [FIELD_W-1:0] b;
        logic [FIELD_W-1:0] e;
        logic [32:0]        span;
        int                 pick;
        int                 bits;
        set_modulus(modulus);
        calm_stretch = calm;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(9))
                0:       b = '0;
                1:       b = 32'd1;
                2:       b = modulus - 32'd1;
                3:       b = 32'hFFFF_FFFF;
                4:       b = modulus;
                default: b = $urandom;
            endcase
            pick = $urandom_range(99);
            if (pick < 5) begin
                e = '0;
            end else begin
                if (pick < 60) bits = $urandom_range(8, 1);
                else if (pick < 85) bits = $urandom_range(20, 9);
                else bits = 32;
                span = (33'd1 << bits) - 33'd1;
                e = ($urandom & span[31:0]) | (32'd1 << (bits - 1));
            end
            if (i == count / 2) drain_results();
            send_operands(b, e);
        end
        calm_stretch = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_modulus();
        test_zero_modulus();
        test_wide_moduli();
        test_modulus_two();
        test_random_powers(32'd1, 70, 1'b0);
        test_random_powers(32'd3, 70, 1'b0);
        test_random_powers(32'hFFFF_FFFF, 70, 1'b1);
        test_random_powers(32'hFFFF_FFFB, 70, 1'b0);
        test_random_powers(32'h8000_0000, 70, 1'b0);
        test_random_powers($urandom_range(1000, 4), 70, 1'b0);
        test_random_powers($urandom | 32'h8000_0000, 70, 1'b0);
        test_random_powers(32'd2, 70, 1'b0);
        drain_results();
        repeat (64) @(posedge aclk);
        if (power_expected.size() != 0)
            note_failure($sformatf("%0d results never arrived", power_expected.size()));
        $display("Sent %0d base/exponent pairs and checked %0d results", items_sent,
                 results_checked);
        $display("over %0d modulus writes, modulus 0, 1, 2 and 2**32-1 included", modulus_writes);
        if (failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d failures", failures);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
